// ----- sv/salte_pkg.sv -----
package salte_pkg;

  localparam int unsigned ADDR_BITS   = 31;
  localparam int unsigned STAMP_BITS  = 32;
  localparam int unsigned WAY_BITS    = 2;
  localparam int unsigned INDEX_BITS  = 6;
  localparam int unsigned OFFSET_BITS = 4;

  typedef enum logic [1:0] {
    REQ_READ     = 2'd0,
    REQ_PREFETCH = 2'd1,
    REQ_SERVICE  = 2'd2,
    REQ_NONE     = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_FILLED   = 3'd1,
    ST_QUEUED   = 3'd2,
    ST_SKIPPED  = 3'd3,
    ST_DROPPED  = 3'd4,
    ST_SERVICED = 3'd5,
    ST_IDLE     = 3'd6
  } status_e;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [ADDR_BITS-1:0] address;
  } req_t;

  typedef struct packed {
    logic [2:0]             status;
    logic [WAY_BITS-1:0]    way;
    logic [INDEX_BITS-1:0]  set_index;
    logic [OFFSET_BITS-1:0] word_offset;
    logic [ADDR_BITS-1:0]   line_address;
  } rsp_t;

  // Work passed from the front end to the set engine.
  typedef struct packed {
    logic                 lookup;   // read: hit or fill; else install
    logic                 idle;     // no set access, fixed-status result
    status_e              status;   // fixed status for non-set words
    logic [ADDR_BITS-1:0] address;
  } job_t;

endpackage

// ----- sv/salte_ram.sv -----
module salte_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- sv/salte_front.sv -----
// Classifies words. Prefetch presence checks need the tag store, so the front
// end only forwards read, service and idle work and handles prefetch after
// asking the set engine for a presence probe.
module salte_front
  import salte_pkg::*;
#(
  parameter int unsigned PENDING_DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  logic req_valid_i,
  output logic req_ready_o,
  // probe to set engine
  output logic                 probe_valid_o,
  output logic [ADDR_BITS-1:0] probe_addr_o,
  input  logic                 probe_done_i,
  input  logic                 probe_hit_i,
  // job queue
  output job_t job_o,
  output logic job_valid_o,
  input  logic job_ready_i
);

  localparam int unsigned PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int unsigned CW = $clog2(PENDING_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_PROBE, S_WAIT} state_e;

  state_e                state_q;
  req_t                  cur_q;
  logic [CW-1:0]         cnt_q;
  logic [ADDR_BITS-1:0]  stack_q [PENDING_DEPTH];
  logic [PENDING_DEPTH-1:0] match;
  logic                  pending;
  logic [ADDR_BITS-1:0]  line;
  logic [ADDR_BITS-1:0]  top;
  job_t                  job;

  assign line = {cur_q.address[ADDR_BITS-1:OFFSET_BITS], OFFSET_BITS'(0)};

  always_comb begin
    for (int k = 0; k < PENDING_DEPTH; k++) begin
      match[k] = (CW'(k) < cnt_q) && (stack_q[k] == line);
    end
  end
  assign pending = |match;
  assign top = (cnt_q != '0) ? stack_q[PW'(cnt_q - CW'(1))] : '0;

  assign req_ready_o   = (state_q == S_IDLE);
  assign probe_valid_o = (state_q == S_PROBE);
  assign probe_addr_o  = cur_q.address;
  assign job_valid_o   = (state_q == S_WAIT);
  assign job_o         = job;

  always_comb begin
    job = '{lookup: 1'b0, idle: 1'b1, status: ST_IDLE, address: '0};
    case (req_e'(cur_q.req_type))
      REQ_READ: begin
        job.lookup  = 1'b1;
        job.idle    = 1'b0;
        job.address = cur_q.address;
      end
      REQ_SERVICE: begin
        if (cnt_q != '0) begin
          job.idle    = 1'b0;
          job.address = top;
          job.status  = ST_SERVICED;
        end
      end
      REQ_PREFETCH: begin
        job.address = line;
        if (probe_hit_i || pending) job.status = ST_SKIPPED;
        else if (cnt_q >= CW'(PENDING_DEPTH)) job.status = ST_DROPPED;
        else job.status = ST_QUEUED;
      end
      default: job.address = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            state_q <= (req_e'(req_i.req_type) == REQ_PREFETCH) ? S_PROBE : S_WAIT;
          end
        end
        S_PROBE: if (probe_done_i) state_q <= S_WAIT;
        S_WAIT: begin
          if (job_ready_i) begin
            state_q <= S_IDLE;
            if (req_e'(cur_q.req_type) == REQ_SERVICE && cnt_q != '0) begin
              cnt_q <= cnt_q - CW'(1);
            end
            if (req_e'(cur_q.req_type) == REQ_PREFETCH && job.status == ST_QUEUED) begin
              cnt_q <= cnt_q + CW'(1);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Probe hit is held by the set engine until the next probe.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_valid_i) cur_q <= req_i;
    if (state_q == S_WAIT && job_ready_i && req_e'(cur_q.req_type) == REQ_PREFETCH &&
        job.status == ST_QUEUED) begin
      stack_q[PW'(cnt_q)] <= line;
    end
  end

endmodule

// ----- sv/salte_back.sv -----
// Set engine: one read-modify-write of the set per read or service word, plus presence probes.
module salte_back
  import salte_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic                 probe_valid_i,
  input  logic [ADDR_BITS-1:0] probe_addr_i,
  output logic                 probe_done_o,
  output logic                 probe_hit_o,
  input  job_t                 job_i,
  input  logic                 job_valid_i,
  output logic                 job_ready_o,
  output rsp_t                 rsp_o,
  output logic                 rsp_valid_o,
  input  logic                 rsp_ready_i
);

  localparam int unsigned NW  = 1 << WAY_BITS;
  localparam int unsigned NS  = 1 << INDEX_BITS;
  localparam int unsigned TB  = ADDR_BITS - OFFSET_BITS - INDEX_BITS;
  localparam int unsigned WB  = (WAY_BITS > 0) ? WAY_BITS : 1;
  localparam int unsigned ENT = 1 + TB + STAMP_BITS;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_WORK, S_OUT} state_e;

  state_e               state_q;
  logic                 is_probe_q;
  job_t                 job_q;
  logic [STAMP_BITS-1:0] stamp_q;
  logic [NS-1:0]        vld_q [NW];
  logic [ENT*NW-1:0]    rd;
  logic [NW-1:0]        we;
  logic [TB+STAMP_BITS-1:0] wdata;
  logic [INDEX_BITS-1:0] set_a;
  logic [TB-1:0]        tag_a;
  logic [ADDR_BITS-1:0] addr_a;
  logic                 hit;
  logic [WB-1:0]        hit_way, fill_way, sel_way;
  rsp_t                 rsp_q, rsp_d;
  logic                 phit_q;

  assign addr_a = is_probe_q ? probe_addr_i : job_q.address;
  assign set_a  = addr_a[OFFSET_BITS +: INDEX_BITS];
  assign tag_a  = addr_a[ADDR_BITS-1 -: TB];

  for (genvar w = 0; w < NW; w++) begin : g_way
    salte_ram #(.Width(TB + STAMP_BITS), .Depth(NS)) u_ram (
      .clk_i  (clk_i),
      .we_i   (we[w]),
      .waddr_i(set_a),
      .wdata_i(wdata),
      .raddr_i(set_a),
      .rdata_o(rd[w*ENT +: TB+STAMP_BITS])
    );
    assign rd[w*ENT+TB+STAMP_BITS] = vld_q[w][set_a];
  end

  always_comb begin
    logic [STAMP_BITS-1:0] best;
    logic                  found_inv;
    hit = 1'b0; hit_way = '0; fill_way = '0;
    best = '1; found_inv = 1'b0;
    for (int w = NW-1; w >= 0; w--) begin
      if (rd[w*ENT+TB+STAMP_BITS] && rd[w*ENT+STAMP_BITS +: TB] == tag_a) begin
        hit = 1'b1; hit_way = WB'(w);
      end
    end
    for (int w = 0; w < NW; w++) begin
      if (!found_inv) begin
        if (!rd[w*ENT+TB+STAMP_BITS]) begin
          found_inv = 1'b1; fill_way = WB'(w);
        end else if (rd[w*ENT +: STAMP_BITS] < best) begin
          best = rd[w*ENT +: STAMP_BITS]; fill_way = WB'(w);
        end
      end
    end
  end

  assign sel_way = (job_q.lookup && hit) ? hit_way : fill_way;
  assign wdata   = {(job_q.lookup && hit) ? rd[sel_way*ENT+STAMP_BITS +: TB] : tag_a,
                    stamp_q};
  always_comb begin
    for (int w = 0; w < NW; w++) begin
      we[w] = (state_q == S_WORK) && !is_probe_q && (sel_way == WB'(w));
    end
  end

  assign probe_done_o = (state_q == S_WORK) && is_probe_q;
  assign probe_hit_o  = phit_q;
  assign job_ready_o  = (state_q == S_IDLE) && !probe_valid_i;
  assign rsp_o        = rsp_q;
  assign rsp_valid_o  = (state_q == S_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      stamp_q    <= '0;
      is_probe_q <= 1'b0;
      phit_q     <= 1'b0;
      for (int w = 0; w < NW; w++) vld_q[w] <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (probe_valid_i) begin
            is_probe_q <= 1'b1;
            state_q    <= S_READ;
          end else if (job_valid_i) begin
            is_probe_q <= 1'b0;
            state_q    <= job_i.idle ? S_OUT : S_READ;
          end
        end
        S_READ: state_q <= S_WORK;
        S_WORK: begin
          if (is_probe_q) begin
            phit_q  <= hit;
            state_q <= S_IDLE;
          end else begin
            vld_q[sel_way][set_a] <= 1'b1;
            stamp_q <= stamp_q + STAMP_BITS'(1);
            state_q <= S_OUT;
          end
        end
        S_OUT: if (rsp_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    rsp_d = rsp_q;
    if (state_q == S_IDLE && !probe_valid_i && job_valid_i) begin
      rsp_d = '0;
      if (job_i.idle) begin
        rsp_d.status       = job_i.status;
        rsp_d.line_address = job_i.address;
        if (job_i.status != ST_IDLE) begin
          rsp_d.set_index = job_i.address[OFFSET_BITS +: INDEX_BITS];
        end
      end
    end
    if (state_q == S_WORK && !is_probe_q) begin
      rsp_d.way          = sel_way;
      rsp_d.set_index    = set_a;
      rsp_d.line_address = {job_q.address[ADDR_BITS-1:OFFSET_BITS], OFFSET_BITS'(0)};
      if (job_q.lookup) begin
        rsp_d.status      = hit ? ST_HIT : ST_FILLED;
        rsp_d.word_offset = job_q.address[OFFSET_BITS-1:0];
      end else begin
        rsp_d.status      = ST_SERVICED;
        rsp_d.word_offset = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && !probe_valid_i && job_valid_i) job_q <= job_i;
    rsp_q <= rsp_d;
  end

endmodule

// ----- sv/set_assoc_lru_tag_engine.sv -----
// A word's path, accept to result accept: read and service words pass the set
// memory read-modify-write (accept, read, compare and write back, output); a
// prefetch first has the set engine probe the set for presence; idle words go
// straight to the output. The set engine takes one word at a time and is held
// by each read-modify-write and each probe until it is through with it.
// Reset clears valid marks, the stamp counter and the pending count at once;
// tag and stamp memories hold no reset value.
module set_assoc_lru_tag_engine
  import salte_pkg::*;
#(
  parameter int unsigned PENDING_DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t in_data_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  output rsp_t out_data_o,
  output logic out_valid_o,
  input  logic out_ready_i
);

  logic                 probe_valid, probe_done, probe_hit;
  logic [ADDR_BITS-1:0] probe_addr;
  job_t                 job;
  logic                 job_valid, job_ready;

  salte_front #(.PENDING_DEPTH(PENDING_DEPTH)) u_front (
    .clk_i, .rst_ni,
    .req_i(in_data_i), .req_valid_i(in_valid_i), .req_ready_o(in_ready_o),
    .probe_valid_o(probe_valid), .probe_addr_o(probe_addr),
    .probe_done_i(probe_done), .probe_hit_i(probe_hit),
    .job_o(job), .job_valid_o(job_valid), .job_ready_i(job_ready)
  );

  salte_back u_back (
    .clk_i, .rst_ni,
    .probe_valid_i(probe_valid), .probe_addr_i(probe_addr),
    .probe_done_o(probe_done), .probe_hit_o(probe_hit),
    .job_i(job), .job_valid_i(job_valid), .job_ready_o(job_ready),
    .rsp_o(out_data_o), .rsp_valid_o(out_valid_o), .rsp_ready_i(out_ready_i)
  );

endmodule

// ----- tb/sv/tb_set_assoc_lru_tag_engine.sv -----
module tb_set_assoc_lru_tag_engine;
  import salte_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NWAYS = 4;
  localparam int unsigned NSETS = 64;
  localparam int unsigned DEPTH = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  req_t in_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  rsp_t out_data;
  logic out_valid;
  logic out_ready = 1'b0;

  set_assoc_lru_tag_engine dut (
    .clk_i(clk), .rst_ni(rst_n), .in_data_i(in_data), .in_valid_i(in_valid),
    .in_ready_o(in_ready), .out_data_o(out_data), .out_valid_o(out_valid),
    .out_ready_i(out_ready)
  );

  always #2 clk = ~clk;

  // predictor copy of the cache state
  logic         cv_valid [NSETS][NWAYS];
  logic [20:0]  cv_tag   [NSETS][NWAYS];
  logic [31:0]  cv_stamp [NSETS][NWAYS];
  logic [31:0]  stamp_now;
  logic [30:0]  pend_lines [DEPTH];
  int unsigned  pend_cnt;

  req_t word_q [$];
  rsp_t rsp_q [$];
  int   mism = 0;
  bit   quiet = 0;     // no idling stretch
  bit   hold_rx = 0;   // long receiver hold-off

  function automatic int find_line(input logic [5:0] s, input logic [20:0] t);
    for (int w = 0; w < NWAYS; w++)
      if (cv_valid[s][w] && cv_tag[s][w] == t) return w;
    return -1;
  endfunction

  function automatic logic [1:0] fill_line(input logic [5:0] s, input logic [20:0] t);
    int pick;
    logic [31:0] best;
    pick = 0;
    best = '1;
    for (int w = 0; w < NWAYS; w++) begin
      if (!cv_valid[s][w]) begin
        pick = w;
        break;
      end
      if (cv_stamp[s][w] < best) begin
        best = cv_stamp[s][w];
        pick = w;
      end
    end
    cv_valid[s][pick] = 1'b1;
    cv_tag[s][pick] = t;
    cv_stamp[s][pick] = stamp_now;
    stamp_now++;
    return pick[1:0];
  endfunction

  function automatic rsp_t cache_predict(input req_t r);
    rsp_t o;
    int w;
    bit hit_pend;
    logic [30:0] a;
    o = '0;
    o.status = ST_IDLE;
    a = r.address;
    case (req_e'(r.req_type))
      REQ_READ: begin
        o.set_index = a[9:4];
        o.word_offset = a[3:0];
        o.line_address = {a[30:4], 4'b0};
        w = find_line(a[9:4], a[30:10]);
        if (w >= 0) begin
          cv_stamp[a[9:4]][w] = stamp_now;
          stamp_now++;
          o.status = ST_HIT;
          o.way = w[1:0];
        end else begin
          o.way = fill_line(a[9:4], a[30:10]);
          o.status = ST_FILLED;
        end
      end
      REQ_PREFETCH: begin
        o.set_index = a[9:4];
        o.line_address = {a[30:4], 4'b0};
        hit_pend = 0;
        for (int k = 0; k < pend_cnt; k++)
          if (pend_lines[k] == o.line_address) hit_pend = 1;
        if (find_line(a[9:4], a[30:10]) >= 0 || hit_pend) o.status = ST_SKIPPED;
        else if (pend_cnt >= DEPTH) o.status = ST_DROPPED;
        else begin
          pend_lines[pend_cnt] = o.line_address;
          pend_cnt++;
          o.status = ST_QUEUED;
        end
      end
      REQ_SERVICE: begin
        if (pend_cnt > 0) begin
          pend_cnt--;
          o.line_address = pend_lines[pend_cnt];
          o.set_index = o.line_address[9:4];
          o.way = fill_line(o.line_address[9:4], o.line_address[30:10]);
          o.status = ST_SERVICED;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        rsp_q.insert(rsp_q.size(), cache_predict(in_data));
      end
      if (!in_valid || in_ready) begin
        if (word_q.size() > 0 && (quiet || $urandom_range(99) >= 20)) begin
          in_data <= word_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (rsp_q.size() == 0) begin
          mism++;
          if (mism <= 10) $display("unexpected word %h", out_data);
        end else begin
          rsp_t e;
          e = rsp_q.pop_front();
          if (e.status !== out_data.status || e.way !== out_data.way ||
              e.set_index !== out_data.set_index ||
              e.word_offset !== out_data.word_offset ||
              e.line_address !== out_data.line_address) begin
            mism++;
            if (mism <= 10)
              $display({"mismatch: exp st=%0d way=%0d set=%0d off=%0d line=%h, ",
                        "got st=%0d way=%0d set=%0d off=%0d line=%h"},
                       e.status, e.way, e.set_index, e.word_offset, e.line_address,
                       out_data.status, out_data.way, out_data.set_index,
                       out_data.word_offset, out_data.line_address);
          end
        end
      end
      out_ready <= !hold_rx && (quiet || $urandom_range(99) >= 20);
    end
  end

  // receiver hold-off while the sender keeps offering, then a stretch with no idling
  initial begin
    wait (rst_n);
    repeat (3000) @(posedge clk);
    hold_rx = 1;
    repeat (200) @(posedge clk);
    hold_rx = 0;
    repeat (1500) @(posedge clk);
    quiet = 1;
    repeat (1500) @(posedge clk);
    quiet = 0;
  end

  function automatic logic [30:0] mk_addr(input logic [20:0] t, input logic [5:0] s,
                                          input logic [3:0] o);
    return {t, s, o};
  endfunction

  task automatic push_word(input req_e k, input logic [30:0] a);
    req_t r;
    r.req_type = k;
    r.address = a;
    word_q.insert(word_q.size(), r);
  endtask

  initial begin
    logic [20:0] tags [8];
    int n;
    foreach (cv_valid[s, w]) cv_valid[s][w] = 1'b0;
    stamp_now = '0;
    pend_cnt = 0;
    // directed: extremes, hits, eviction, prefetch cases, service cases
    push_word(REQ_SERVICE, '0);                      // empty stack: idle
    push_word(REQ_READ, '0);
    push_word(REQ_READ, 31'h7fffffff);
    push_word(REQ_READ, 31'h0000000f);               // hit
    for (int i = 1; i <= 4; i++) push_word(REQ_READ, mk_addr(21'(i), 6'd5, 4'd3));
    push_word(REQ_READ, mk_addr(21'd1, 6'd5, 4'd0));   // refresh
    push_word(REQ_READ, mk_addr(21'd9, 6'd5, 4'd0));   // evict oldest
    push_word(REQ_PREFETCH, mk_addr(21'd1, 6'd5, 4'd0));  // present: skipped
    push_word(REQ_PREFETCH, mk_addr(21'd33, 6'd7, 4'd1));
    push_word(REQ_PREFETCH, mk_addr(21'd33, 6'd7, 4'd9));  // pending: skipped
    push_word(REQ_READ, mk_addr(21'd33, 6'd7, 4'd2));  // pending only: filled
    push_word(REQ_SERVICE, '0);                      // duplicate install
    push_word(REQ_READ, mk_addr(21'd33, 6'd7, 4'd2));
    for (int i = 0; i < 17; i++)
      push_word(REQ_PREFETCH, mk_addr(21'(100 + i), i[5:0], 4'd0));
    push_word(REQ_NONE, 31'h2aaaaaaa);
    push_word(REQ_NONE, 31'h55555555);
    // random: small tag pool to get hits and evictions
    for (int i = 0; i < 8; i++) tags[i] = 21'($urandom());
    n = 0;
    while (n < 1850) begin
      logic [30:0] a;
      int p;
      if ($urandom_range(9) < 8)
        a = mk_addr(tags[$urandom_range(7)], 6'($urandom_range(3)), 4'($urandom()));
      else a = 31'($urandom());
      p = $urandom_range(99);
      if (p < 50) push_word(REQ_READ, a);
      else if (p < 75) push_word(REQ_PREFETCH, a);
      else if (p < 97) push_word(REQ_SERVICE, 31'($urandom()));
      else push_word(REQ_NONE, a);
      n++;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (word_q.size() != 0 || in_valid || rsp_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mism == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
